// File: rtl/core/signed_number_to_letter_string_assert.svh
// assertion macros shared by the rtl files of the letter string converter
`ifndef SIGNED_NUMBER_TO_LETTER_STRING_ASSERT_SVH
`define SIGNED_NUMBER_TO_LETTER_STRING_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SNTL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SNTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sntl_pkg.sv
package sntl_pkg;

    localparam int VALUE_W    = 64;
    localparam int DIGIT_W    = 5;
    localparam int CNT_W      = 4;
    localparam int CHAR_W     = 8;
    localparam int RADIX      = 26;
    localparam int MAX_DIGITS = 14;

    localparam logic [CHAR_W-1:0] LETTER_BASE = 8'h60;
    localparam logic [CHAR_W-1:0] MINUS_CHAR  = 8'h2D;
    localparam logic [CHAR_W-1:0] EMPTY_CHAR  = 8'h00;

    // status of the divide-by-radix unit
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: rtl/core/sntl_div26.sv
`include "signed_number_to_letter_string_assert.svh"

module sntl_div26
    import sntl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [VALUE_W-1:0]  dividend,
    output logic [VALUE_W-1:0]  quotient,
    output logic [DIGIT_W-1:0]  remainder,
    output div_status_t         status
);

    localparam int BITS_PER_STEP = 8;
    localparam int STEPS         = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(STEPS);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [VALUE_W-1:0] shift_reg;
    logic [DIGIT_W-1:0] rem_reg;

    logic [BITS_PER_STEP-1:0] qbyte;
    logic [DIGIT_W-1:0]       rem_new;

    // long division of one chunk by the radix, remainder stays below the radix
    function automatic logic [BITS_PER_STEP+DIGIT_W-1:0] div_chunk(
        input logic [DIGIT_W-1:0]       r_in,
        input logic [BITS_PER_STEP-1:0] bits
    );
        logic [DIGIT_W-1:0]       r;
        logic [DIGIT_W:0]         t;
        logic [BITS_PER_STEP-1:0] q;
        r = r_in;
        q = '0;
        for (int i = BITS_PER_STEP - 1; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= (DIGIT_W+1)'(RADIX)) begin
                q[i] = 1'b1;
                r    = DIGIT_W'(t - (DIGIT_W+1)'(RADIX));
            end
            else begin
                r = t[DIGIT_W-1:0];
            end
        end
        return {q, r};
    endfunction

    assign {qbyte, rem_new} = div_chunk(rem_reg, shift_reg[VALUE_W-1 -: BITS_PER_STEP]);

    // one chunk per cycle, quotient bits shift in behind the dividend
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[VALUE_W-BITS_PER_STEP-1:0], qbyte};
            rem_reg   <= rem_new;
        end
    end

    assign quotient    = shift_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    `SNTL_ASSERT_IMPL(a_rem_below_radix, busy_reg || done_reg, rem_reg < DIGIT_W'(RADIX), "remainder reached the radix")
    `SNTL_ASSERT_NEXT(a_done_ends_busy, busy_reg && step_reg == STEP_W'(STEPS - 1) && !start, done_reg && !busy_reg, "divide did not finish on the last step")
    `SNTL_ASSERT_IMPL(a_done_not_busy, done_reg, !busy_reg, "done while still busy")

endmodule

// File: rtl/core/signed_number_to_letter_string.sv
`include "signed_number_to_letter_string_assert.svh"

// Converts a signed 64-bit value into its bijective base-26 letters ('a' = 1 .. 'z' = 26),
// most significant letter first, one character per transfer on the char channel; a negative
// value is sent as '-' followed by the letters of its magnitude, the most negative value
// converts as 2^63, and zero gives a single transfer with is_empty set and str_length 0.
// Every character carries the total length and the final one has is_last set. item_ready
// is high only while the converter is idle. Each of the D letters of a conversion takes
// a pass through the check state plus one pass of the shared divide-by-26 unit, which
// works 8 bits per cycle and raises done once its last chunk is in. The characters then
// leave at one per cycle while char_ready is high; the worst case is 14 letters and the
// sign, 15 characters. The next item is taken as soon as the last character sits in the
// output register.
module signed_number_to_letter_string
    import sntl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      char_valid,
    input  logic                      char_ready,
    output logic [CHAR_W-1:0]         out_char,
    output logic                      is_last,
    output logic                      is_empty,
    output logic [CNT_W-1:0]          str_length
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_EMPTY,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [VALUE_W-1:0] work_reg, work_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               char_valid_reg, char_valid_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic               is_last_reg, is_last_next;
    logic               is_empty_reg, is_empty_next;
    logic [CNT_W-1:0]   str_length_reg, str_length_next;

    logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];

    logic               div_start;
    logic [VALUE_W-1:0] div_quot;
    logic [DIGIT_W-1:0] div_rem;
    div_status_t        div_st;

    logic               slot_free;
    logic [CNT_W-1:0]   total;
    logic [CNT_W-1:0]   pos;
    logic [DIGIT_W-1:0] digit;
    logic               last_char;

    // shared divide-by-radix unit, fed with the value less one
    sntl_div26 u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (work_reg - VALUE_W'(1)),
        .quotient  (div_quot),
        .remainder (div_rem),
        .status    (div_st)
    );

    // character selection, digits read back most significant first
    assign slot_free = !char_valid_reg || char_ready;
    assign total     = count_reg + CNT_W'(neg_reg);
    assign pos       = count_reg - CNT_W'(1) - (idx_reg - CNT_W'(neg_reg));
    assign digit     = digit_store[pos];
    assign last_char = (idx_reg + CNT_W'(1)) == total;

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        work_next       = work_reg;
        neg_next        = neg_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        char_valid_next = char_valid_reg && !char_ready;
        out_char_next   = out_char_reg;
        is_last_next    = is_last_reg;
        is_empty_next   = is_empty_reg;
        str_length_next = str_length_reg;
        div_start       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    neg_next   = value[VALUE_W-1];
                    work_next  = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
                    count_next = '0;
                    idx_next   = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (work_reg == '0)
                begin
                    state_next = (count_reg == '0) ? S_EMPTY : S_EMIT;
                end
                else if (count_reg == CNT_W'(MAX_DIGITS))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_st.done)
                begin
                    work_next  = div_quot;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_CHECK;
                end
            end
            S_EMPTY:
            begin
                if (slot_free)
                begin
                    char_valid_next = 1'b1;
                    out_char_next   = EMPTY_CHAR;
                    is_last_next    = 1'b1;
                    is_empty_next   = 1'b1;
                    str_length_next = '0;
                    state_next      = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    char_valid_next = 1'b1;
                    if (neg_reg && idx_reg == '0)
                        out_char_next = MINUS_CHAR;
                    else
                        out_char_next = LETTER_BASE + CHAR_W'(digit);
                    is_last_next    = last_char;
                    is_empty_next   = 1'b0;
                    str_length_next = total;
                    idx_next        = idx_reg + CNT_W'(1);
                    if (last_char)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            work_reg       <= '0;
            neg_reg        <= 1'b0;
            count_reg      <= '0;
            idx_reg        <= '0;
            char_valid_reg <= 1'b0;
            out_char_reg   <= '0;
            is_last_reg    <= 1'b0;
            is_empty_reg   <= 1'b0;
            str_length_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            work_reg       <= work_next;
            neg_reg        <= neg_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            char_valid_reg <= char_valid_next;
            out_char_reg   <= out_char_next;
            is_last_reg    <= is_last_next;
            is_empty_reg   <= is_empty_next;
            str_length_reg <= str_length_next;
        end
    end

    // digit store, least significant digit first
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV && div_st.done)
            digit_store[count_reg] <= div_rem + DIGIT_W'(1);
    end

    assign item_ready = (state_reg == S_IDLE);
    assign char_valid = char_valid_reg;
    assign out_char   = out_char_reg;
    assign is_last    = is_last_reg;
    assign is_empty   = is_empty_reg;
    assign str_length = str_length_reg;

    `SNTL_ASSERT_IMPL(a_idle_div_quiet, state_reg == S_IDLE, !div_st.busy, "divider busy while idle")
    `SNTL_ASSERT_IMPL(a_done_in_div, div_st.done, state_reg == S_DIV, "divider finished outside divide state")
    `SNTL_ASSERT_IMPL(a_count_bound, state_reg == S_DIV, count_reg < CNT_W'(MAX_DIGITS), "digit store overrun")
    `SNTL_ASSERT_IMPL(a_empty_zero_len, char_valid_reg && is_empty_reg, str_length_reg == '0 && is_last_reg, "empty result with length")

endmodule

// File: bench/signed_number_to_letter_string_tb.sv
module signed_number_to_letter_string_tb;
    import sntl_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_ITEMS   = 40;
    localparam int DRAIN_CYCLES = 160;

    // one character transfer on the output side
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              empty;
        logic [CNT_W-1:0]  len;
    } letter_t;

    // letter string predictor and pending character store
    class letter_scoreboard;
        letter_t pending_letters[$];
        int      failures;

        function new();
            failures = 0;
        endfunction

        // expand one accepted value into its expected characters
        function void note_value(logic [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] mag;
            logic [VALUE_W-1:0] quot;
            logic [VALUE_W-1:0] rem;
            logic [DIGIT_W-1:0] digits [MAX_DIGITS];
            int                 count;
            int                 total;
            bit                 neg;
            letter_t            entry;
            neg = v[VALUE_W-1];
            mag = neg ? (~v + 1'b1) : v;
            if (mag == '0)
            begin
                entry = '{EMPTY_CHAR, 1'b1, 1'b1, '0};
                pending_letters.push_back(entry);
                return;
            end
            // bijective division, each digit lands in 1..26
            count = 0;
            while (mag != '0 && count < MAX_DIGITS)
            begin
                quot = (mag - 1'b1) / 64'(RADIX);
                rem  = mag - quot * 64'(RADIX);
                digits[count] = rem[DIGIT_W-1:0];
                count++;
                mag = quot;
            end
            total = count + int'(neg);
            if (neg)
            begin
                entry = '{MINUS_CHAR, (total == 1), 1'b0, CNT_W'(total)};
                pending_letters.push_back(entry);
            end
            // most significant letter first
            for (int k = 0; k < count; k++)
            begin
                entry.ch    = LETTER_BASE + CHAR_W'(digits[count-1-k]);
                entry.last  = (k == count - 1);
                entry.empty = 1'b0;
                entry.len   = CNT_W'(total);
                pending_letters.push_back(entry);
            end
        endfunction

        // compare one character transfer against the oldest expectation
        function void check_char(letter_t got);
            letter_t want;
            if (pending_letters.size() == 0)
            begin
                $display("%0t: unexpected character, expected none, %s %h last %b empty %b len %0d",
                         $time, "actual char", got.ch, got.last, got.empty, got.len);
                failures++;
                return;
            end
            want = pending_letters.pop_front();
            if (got.ch !== want.ch)
            begin
                $display("%0t: out_char mismatch, expected %h, actual %h",
                         $time, want.ch, got.ch);
                failures++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: is_last mismatch, expected %b, actual %b",
                         $time, want.last, got.last);
                failures++;
            end
            if (got.empty !== want.empty)
            begin
                $display("%0t: is_empty mismatch, expected %b, actual %b",
                         $time, want.empty, got.empty);
                failures++;
            end
            if (got.len !== want.len)
            begin
                $display("%0t: str_length mismatch, expected %0d, actual %0d",
                         $time, want.len, got.len);
                failures++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      item_valid;
    logic                      item_ready;
    logic signed [VALUE_W-1:0] value;
    logic                      char_valid;
    logic                      char_ready;
    logic [CHAR_W-1:0]         out_char;
    logic                      is_last;
    logic                      is_empty;
    logic [CNT_W-1:0]          str_length;

    letter_scoreboard sb = new();
    bit               calm = 1'b0;

    // boundaries of digit counts, sign edges and bit patterns
    logic [VALUE_W-1:0] corners [20] = '{
        64'd0, 64'd1, -64'sd1, 64'd25, 64'd26, 64'd27, -64'sd26, -64'sd27,
        64'd52, 64'd53, 64'd702, 64'd703, -64'sd703, 64'd18278, 64'd18279,
        64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA
    };

    signed_number_to_letter_string dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .value      (value),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .out_char   (out_char),
        .is_last    (is_last),
        .is_empty   (is_empty),
        .str_length (str_length)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // observe transfers on both channels
    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
            sb.note_value(value);
        if (rst_n && char_valid && char_ready)
            sb.check_char('{out_char, is_last, is_empty, str_length});
    end

    // mix of corner, full-width, short-magnitude and power-of-26 boundary values
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] r;
        logic [VALUE_W-1:0] p;
        int                 k;
        case ($urandom_range(0, 9))
            0: r = corners[$urandom_range(0, 19)];
            1, 2, 3: r = {$urandom, $urandom};
            4, 5, 6, 7:
            begin
                r = {$urandom, $urandom} >> $urandom_range(1, 63);
                if ($urandom_range(0, 1))
                    r = ~r + 1'b1;
            end
            default:
            begin
                p = 64'd1;
                k = $urandom_range(1, 13);
                repeat (k) p = p * 64'(RADIX);
                r = p - 64'd2 + 64'($urandom_range(0, 4));
                if ($urandom_range(0, 1))
                    r = ~r + 1'b1;
            end
        endcase
        return r;
    endfunction

    // offer one value and hold it until the transfer, then maybe pause
    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        item_valid <= 1'b1;
        value      <= v;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            item_valid <= 1'b0;
            value      <= {$urandom, $urandom};
            repeat (gap) @(posedge clk);
        end
    endtask

    // step past the current edge so its transfer is noted, then wait for all characters
    task automatic wait_drained();
        @(posedge clk);
        while (sb.pending_letters.size() != 0)
            @(posedge clk);
    endtask

    // receiver stalls in random bursts
    initial
    begin
        int n;
        char_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                char_ready <= 1'b0;
                n = $urandom_range(1, 8);
                repeat (n) @(posedge clk);
            end
            char_ready <= 1'b1;
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            repeat (n) @(posedge clk);
        end
    end

    // reset, directed values, random values, drain
    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        value      = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corners[i])
            send_value(corners[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            send_value(pick_value());
            // let the converter empty out completely once
            if (i == RANDOM_ITEMS / 2)
            begin
                item_valid <= 1'b0;
                wait_drained();
                repeat (4) @(posedge clk);
            end
        end
        item_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending_letters.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
